// ----- hw/rtl/utf8_script_detector_macros.svh -----
// ----------------------------------------------------------------------------
// UTF-8 script detector assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_SCRIPT_DETECTOR_MACROS_SVH
`define UTF8_SCRIPT_DETECTOR_MACROS_SVH

// Plain property check.
`define UTF8SD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define UTF8SD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check.
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/utf8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 script detector package
// Script codes, script range table and UTF-8 lead byte helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8sd_pkg;

	// Script codes as seen on the result port.
	typedef enum logic [3:0] {
		SCRIPT_LATIN      = 4'd0,
		SCRIPT_ARABIC     = 4'd1,
		SCRIPT_HEBREW     = 4'd2,
		SCRIPT_DEVANAGARI = 4'd3,
		SCRIPT_BENGALI    = 4'd4,
		SCRIPT_TAMIL      = 4'd5,
		SCRIPT_THAI       = 4'd6,
		SCRIPT_HAN        = 4'd7,
		SCRIPT_HANGUL     = 4'd8,
		SCRIPT_HIRAGANA   = 4'd9,
		SCRIPT_KATAKANA   = 4'd10
	} script_t;

	localparam int CP_W      = 21;
	localparam int NUM_RANGES = 10;

	// One script range; all ranges lie inside the basic multilingual plane.
	typedef struct packed {
		logic [15:0] lo;
		logic [15:0] hi;
		script_t     code;
	} range_t;

	localparam range_t SCRIPT_RANGES [NUM_RANGES] = '{
		'{lo: 16'h0600, hi: 16'h06FF, code: SCRIPT_ARABIC},
		'{lo: 16'h0590, hi: 16'h05FF, code: SCRIPT_HEBREW},
		'{lo: 16'h0900, hi: 16'h097F, code: SCRIPT_DEVANAGARI},
		'{lo: 16'h0980, hi: 16'h09FF, code: SCRIPT_BENGALI},
		'{lo: 16'h0B80, hi: 16'h0BFF, code: SCRIPT_TAMIL},
		'{lo: 16'h0E00, hi: 16'h0E7F, code: SCRIPT_THAI},
		'{lo: 16'h4E00, hi: 16'h9FFF, code: SCRIPT_HAN},
		'{lo: 16'hAC00, hi: 16'hD7AF, code: SCRIPT_HANGUL},
		'{lo: 16'h3040, hi: 16'h309F, code: SCRIPT_HIRAGANA},
		'{lo: 16'h30A0, hi: 16'h30FF, code: SCRIPT_KATAKANA}
	};

	// Result word handed from the decoder to the output register.
	typedef struct packed {
		script_t code;
		logic    rtl;
	} result_t;

	// Number of continuation bytes a lead byte asks for, zero if no lead.
	function automatic logic [1:0] lead_length(input logic [7:0] c);
		logic [1:0] len;
		len = 2'd0;
		if ((c & 8'hE0) == 8'hC0)
			len = 2'd1;
		else if ((c & 8'hF0) == 8'hE0)
			len = 2'd2;
		else if ((c & 8'hF8) == 8'hF0)
			len = 2'd3;
		return len;
	endfunction

	// Codepoint bits carried by a lead byte of the given length.
	function automatic logic [CP_W-1:0] lead_bits(input logic [7:0] c, input logic [1:0] len);
		logic [CP_W-1:0] bits;
		case (len)
			2'd1:    bits = {{(CP_W-5){1'b0}}, c[4:0]};
			2'd2:    bits = {{(CP_W-4){1'b0}}, c[3:0]};
			default: bits = {{(CP_W-3){1'b0}}, c[2:0]};
		endcase
		return bits;
	endfunction

endpackage

// ----- hw/rtl/utf8sd_classify.sv -----
// ----------------------------------------------------------------------------
// UTF-8 script detector range classifier
// Tests one codepoint against the script ranges and reports the first hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8sd_classify (
	input  logic [utf8sd_pkg::CP_W-1:0] cp,
	output logic                        hit,
	output utf8sd_pkg::script_t         code
);

	logic [utf8sd_pkg::NUM_RANGES-1:0] in_range;
	logic                              in_bmp;

	// Every range sits below 0x10000, so the upper bits must be clear.
	assign in_bmp = (cp[utf8sd_pkg::CP_W-1:16] == '0);

	// One independent compare pair per range.
	always_comb begin
		for (int k = 0; k < utf8sd_pkg::NUM_RANGES; k++) begin
			in_range[k] = in_bmp && (cp[15:0] >= utf8sd_pkg::SCRIPT_RANGES[k].lo)
				&& (cp[15:0] <= utf8sd_pkg::SCRIPT_RANGES[k].hi);
		end
	end

	// First matching range in table order wins.
	always_comb begin
		hit  = 1'b0;
		code = utf8sd_pkg::SCRIPT_LATIN;
		for (int k = utf8sd_pkg::NUM_RANGES - 1; k >= 0; k--) begin
			if (in_range[k]) begin
				hit  = 1'b1;
				code = utf8sd_pkg::SCRIPT_RANGES[k].code;
			end
		end
	end

endmodule

// ----- hw/rtl/utf8sd_core.sv -----
// ----------------------------------------------------------------------------
// UTF-8 script detector decode core
// Holds the open sequence and the latched script, and decodes one word per
// cycle when told to advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8sd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            byte_s1,
	input  logic                  eot_s1,
	output utf8sd_pkg::result_t   result
);

	logic [1:0]                  exp_q;
	logic [utf8sd_pkg::CP_W-1:0] pcp_q;
	logic [7:0]                  held0_q;
	logic [7:0]                  held1_q;
	logic [1:0]                  hc_q;
	logic                        mf_q;
	utf8sd_pkg::script_t         ms_q;

	logic [1:0]                  exp_d;
	logic [utf8sd_pkg::CP_W-1:0] pcp_d;
	logic [7:0]                  held0_d;
	logic [7:0]                  held1_d;
	logic [1:0]                  hc_d;
	logic [utf8sd_pkg::CP_W-1:0] pcp_shift;
	logic [1:0]                  len;
	logic [utf8sd_pkg::CP_W-1:0] main_cp;
	logic                        main_check;
	logic                        main_hit;
	utf8sd_pkg::script_t         main_code;
	logic [utf8sd_pkg::CP_W-1:0] rescan_cp;
	logic                        rescan_check;
	logic                        rescan_hit;
	utf8sd_pkg::script_t         rescan_code;
	logic                        mf_d;
	utf8sd_pkg::script_t         ms_d;
	logic                        mf_end;
	utf8sd_pkg::script_t         ms_end;

	assign pcp_shift = {pcp_q[utf8sd_pkg::CP_W-7:0], byte_s1[5:0]};
	assign len       = utf8sd_pkg::lead_length(byte_s1);

	// Sequence tracking for the word in the input register.
	always_comb begin
		exp_d      = exp_q;
		pcp_d      = pcp_q;
		held0_d    = held0_q;
		held1_d    = held1_q;
		hc_d       = hc_q;
		main_cp    = {{(utf8sd_pkg::CP_W-8){1'b0}}, byte_s1};
		main_check = 1'b0;
		if (exp_q != 2'd0) begin
			if (hc_q == 2'd0)
				held0_d = byte_s1;
			if (hc_q == 2'd1)
				held1_d = byte_s1;
			hc_d  = hc_q + 2'd1;
			exp_d = exp_q - 2'd1;
			pcp_d = pcp_shift;
			if (exp_q == 2'd1) begin
				main_cp    = pcp_shift;
				main_check = 1'b1;
				hc_d       = 2'd0;
				pcp_d      = '0;
			end
		end else if (!byte_s1[7]) begin
			main_check = 1'b1;
		end else if (len != 2'd0) begin
			exp_d = len;
			pcp_d = utf8sd_pkg::lead_bits(byte_s1, len);
			hc_d  = 2'd0;
		end
	end

	// A sequence left open at the end of text can only hide a two-byte
	// sequence in its first two held bytes.
	assign rescan_cp    = {{(utf8sd_pkg::CP_W-11){1'b0}}, held0_d[4:0], held1_d[5:0]};
	assign rescan_check = (exp_d != 2'd0) && (hc_d == 2'd2) && (held0_d[7:5] == 3'b110);

	utf8sd_classify u_main (
		.cp   (main_cp),
		.hit  (main_hit),
		.code (main_code)
	);

	utf8sd_classify u_rescan (
		.cp   (rescan_cp),
		.hit  (rescan_hit),
		.code (rescan_code)
	);

	// First match in text order is kept.
	always_comb begin
		mf_d   = mf_q;
		ms_d   = ms_q;
		if (!mf_q && main_check && main_hit) begin
			mf_d = 1'b1;
			ms_d = main_code;
		end
		mf_end = mf_d;
		ms_end = ms_d;
		if (!mf_d && rescan_check && rescan_hit) begin
			mf_end = 1'b1;
			ms_end = rescan_code;
		end
	end

	// Result word, valid when the final byte is processed.
	always_comb begin
		result.code = mf_end ? ms_end : utf8sd_pkg::SCRIPT_LATIN;
		result.rtl  = (result.code == utf8sd_pkg::SCRIPT_ARABIC)
			|| (result.code == utf8sd_pkg::SCRIPT_HEBREW);
	end

	// Decoder state; the final byte returns everything to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q   <= 2'd0;
			pcp_q   <= '0;
			held0_q <= 8'h00;
			held1_q <= 8'h00;
			hc_q    <= 2'd0;
			mf_q    <= 1'b0;
			ms_q    <= utf8sd_pkg::SCRIPT_LATIN;
		end else if (advance) begin
			if (eot_s1) begin
				exp_q   <= 2'd0;
				pcp_q   <= '0;
				held0_q <= 8'h00;
				held1_q <= 8'h00;
				hc_q    <= 2'd0;
				mf_q    <= 1'b0;
				ms_q    <= utf8sd_pkg::SCRIPT_LATIN;
			end else begin
				exp_q   <= exp_d;
				pcp_q   <= pcp_d;
				held0_q <= held0_d;
				held1_q <= held1_d;
				hc_q    <= hc_d;
				mf_q    <= mf_d;
				ms_q    <= ms_d;
			end
		end
	end

endmodule

// ----- hw/rtl/utf8_script_detector.sv -----
// ----------------------------------------------------------------------------
// UTF-8 script detector
// Decodes a UTF-8 text and reports the script of its first classified
// codepoint, with a right-to-left flag.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle with no gaps of its own: a word
// accepted is decoded from the input register, and the result word for a
// text (one per word flagged end_of_text) is offered on the following cycle
// from the output register. Input is held off only while a finished result
// has not been taken and the next end-of-text word is already waiting in
// the input register; all other words flow through at one per cycle.
`timescale 1ns / 1ps

`include "utf8_script_detector_macros.svh"

module utf8_script_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [3:0] script_code,
	output logic       right_to_left,
	output logic       out_valid,
	input  logic       out_ready
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eot_s1;
	logic                advance;
	utf8sd_pkg::result_t result;
	logic                out_valid_q;
	utf8sd_pkg::script_t code_q;
	logic                rtl_q;

	// The input register moves on unless its final word meets a full output.
	assign advance  = valid_s1 && (!eot_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	utf8sd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.eot_s1  (eot_s1),
		.result  (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eot_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eot_s1) begin
			code_q <= result.code;
			rtl_q  <= result.rtl;
		end
	end

	assign out_valid     = out_valid_q;
	assign script_code   = code_q;
	assign right_to_left = rtl_q;

	// Checks.
	`UTF8SD_ASSERT_IMP(a_rtl_match, out_valid_q,
		rtl_q == ((code_q == utf8sd_pkg::SCRIPT_ARABIC) || (code_q == utf8sd_pkg::SCRIPT_HEBREW)),
		"right_to_left disagrees with script_code")
	`UTF8SD_ASSERT_IMP(a_code_range, out_valid_q, code_q <= utf8sd_pkg::SCRIPT_KATAKANA,
		"script_code out of range")
	`UTF8SD_ASSERT_IMP(a_stall_cause, !in_ready, valid_s1 && eot_s1 && out_valid_q && !out_ready,
		"input stalled without a blocked result")
	`UTF8SD_ASSERT_NEXT(a_result_follows, advance && eot_s1, out_valid_q,
		"final word did not produce a result")

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// UTF-8 script detector testbench
// Sends whole texts one byte per word, predicts the script of each text in a
// scoreboard and checks every result word, with random idles on both sides in most phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int RANDOM_BYTES = 1900;
	localparam int CYCLE_LIMIT  = 200000;

	// Expected result word of one text.
	typedef struct packed {
		utf8sd_pkg::script_t code;
		logic                rtl;
	} text_verdict_t;

	// Scoreboard: tracks the decoder state and queues one verdict per text.
	class script_scoreboard;
		logic [1:0]          cont_left;
		logic [20:0]         cp_acc;
		logic [7:0]          held [3];
		logic [1:0]          held_cnt;
		bit                  latched;
		utf8sd_pkg::script_t latched_script;
		text_verdict_t       verdict_q [$];
		int                  mismatches;
		int                  results_seen;
		int                  texts_done;
		int                  open_at_end;
		int                  script_hits [11];

		function void clear_decoder();
			cont_left      = 2'd0;
			cp_acc         = '0;
			held_cnt       = 2'd0;
			latched        = 1'b0;
			latched_script = utf8sd_pkg::SCRIPT_LATIN;
			foreach (held[k])
				held[k] = 8'h00;
		endfunction

		function logic [1:0] cont_count(input logic [7:0] c);
			case (c) inside
				8'b110?????: return 2'd1;
				8'b1110????: return 2'd2;
				8'b11110???: return 2'd3;
				default:     return 2'd0;
			endcase
		endfunction

		function logic [20:0] lead_payload(input logic [7:0] c, input logic [1:0] len);
			case (len)
				2'd1:    return {16'd0, c[4:0]};
				2'd2:    return {17'd0, c[3:0]};
				default: return {18'd0, c[2:0]};
			endcase
		endfunction

		// The first codepoint that falls in a script range wins; ranges are
		// tried in a fixed priority order.
		function void classify(input logic [20:0] cp);
			if (latched)
				return;
			latched = 1'b1;
			if (cp >= 21'h0600 && cp <= 21'h06FF)
				latched_script = utf8sd_pkg::SCRIPT_ARABIC;
			else if (cp >= 21'h0590 && cp <= 21'h05FF)
				latched_script = utf8sd_pkg::SCRIPT_HEBREW;
			else if (cp >= 21'h0900 && cp <= 21'h097F)
				latched_script = utf8sd_pkg::SCRIPT_DEVANAGARI;
			else if (cp >= 21'h0980 && cp <= 21'h09FF)
				latched_script = utf8sd_pkg::SCRIPT_BENGALI;
			else if (cp >= 21'h0B80 && cp <= 21'h0BFF)
				latched_script = utf8sd_pkg::SCRIPT_TAMIL;
			else if (cp >= 21'h0E00 && cp <= 21'h0E7F)
				latched_script = utf8sd_pkg::SCRIPT_THAI;
			else if (cp >= 21'h4E00 && cp <= 21'h9FFF)
				latched_script = utf8sd_pkg::SCRIPT_HAN;
			else if (cp >= 21'hAC00 && cp <= 21'hD7AF)
				latched_script = utf8sd_pkg::SCRIPT_HANGUL;
			else if (cp >= 21'h3040 && cp <= 21'h309F)
				latched_script = utf8sd_pkg::SCRIPT_HIRAGANA;
			else if (cp >= 21'h30A0 && cp <= 21'h30FF)
				latched_script = utf8sd_pkg::SCRIPT_KATAKANA;
			else
				latched = 1'b0;
		endfunction

		// A sequence left open at the end of a text loses its lead; the held
		// payload bytes are decoded again on their own.
		function void rescan_held();
			int          i;
			int          j;
			logic [1:0]  len;
			logic [20:0] cp;
			i = 0;
			while (i < held_cnt) begin
				if (held[i] < 8'h80) begin
					classify({13'd0, held[i]});
					i++;
				end else begin
					len = cont_count(held[i]);
					if (len == 2'd0 || i + len >= held_cnt) begin
						i++;
					end else begin
						cp = lead_payload(held[i], len);
						for (j = 1; j <= len; j++)
							cp = {cp[14:0], held[i + j][5:0]};
						classify(cp);
						i += len + 1;
					end
				end
			end
		endfunction

		// Account for one accepted text word.
		task note_word(input logic [7:0] b, input logic eot);
			logic [1:0]    len;
			text_verdict_t v;
			if (cont_left != 2'd0) begin
				if (held_cnt < 2'd3) begin
					held[held_cnt] = b;
					held_cnt++;
				end
				cp_acc = {cp_acc[14:0], b[5:0]};
				cont_left--;
				if (cont_left == 2'd0) begin
					classify(cp_acc);
					held_cnt = 2'd0;
					cp_acc   = '0;
				end
			end else if (b < 8'h80) begin
				classify({13'd0, b});
			end else begin
				len = cont_count(b);
				if (len != 2'd0) begin
					cont_left = len;
					cp_acc    = lead_payload(b, len);
					held_cnt  = 2'd0;
				end
			end
			if (eot) begin
				if (cont_left != 2'd0) begin
					open_at_end++;
					rescan_held();
				end
				v.code = latched ? latched_script : utf8sd_pkg::SCRIPT_LATIN;
				v.rtl  = (v.code == utf8sd_pkg::SCRIPT_ARABIC
					|| v.code == utf8sd_pkg::SCRIPT_HEBREW);
				verdict_q = {verdict_q, v};
				script_hits[v.code]++;
				texts_done++;
				clear_decoder();
			end
		endtask

		task report(input string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		// Compare one accepted result word with the oldest verdict.
		task check_result(input logic [3:0] code, input logic rtl);
			text_verdict_t v;
			results_seen++;
			if (verdict_q.size() == 0) begin
				report($sformatf("result code %0d with no text pending", code));
				return;
			end
			v = verdict_q.pop_front();
			if (code !== v.code)
				report($sformatf("script_code %0d, expected %0d (%s)", code, v.code,
					v.code.name()));
			if (rtl !== v.rtl)
				report($sformatf("right_to_left %0b, expected %0b", rtl, v.rtl));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [3:0] script_code;
	logic       right_to_left;
	logic       out_valid;
	logic       out_ready = 1'b0;

	script_scoreboard sb;
	logic [7:0]       text_q [$];
	int               send_idle_pct = 13;
	int               recv_idle_pct = 87;
	int               bytes_sent;
	int               random_bytes;
	int               cycles;

	utf8_script_detector DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.script_code  (script_code),
		.right_to_left(right_to_left),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results pending.", cycles,
				sb.verdict_q.size());
			$display("FAIL utf8_script_detector");
			$finish;
		end
	end

	// Receiver stalls at random.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watch both handshakes and feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_word(text_byte, end_of_text);
			if (out_valid && out_ready)
				sb.check_result(script_code, right_to_left);
		end
	end

	// Offer one word and hold it until it is accepted.
	task drive_word(input logic [7:0] b, input logic eot);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid    <= 1'b1;
		text_byte   <= b;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Send the assembled text with the end flag on its last byte.
	task send_text();
		foreach (text_q[k])
			drive_word(text_q[k], k == text_q.size() - 1);
		bytes_sent += text_q.size();
		text_q.delete();
	endtask

	// Add one byte at the end of the text being built.
	function automatic void append_byte(input logic [7:0] b);
		text_q = {text_q, b};
	endfunction

	function automatic int min_len(input logic [20:0] cp);
		if (cp < 21'h80)
			return 1;
		if (cp < 21'h800)
			return 2;
		if (cp < 21'h10000)
			return 3;
		return 4;
	endfunction

	// Encode a codepoint in a given byte count; a longer count gives an
	// overlong form, which the block decodes all the same.
	function automatic void push_cp(input logic [20:0] cp, input int len);
		case (len)
			1: append_byte({1'b0, cp[6:0]});
			2: append_byte({3'b110, cp[10:6]});
			3: append_byte({4'b1110, cp[15:12]});
			default: append_byte({5'b11110, cp[20:18]});
		endcase
		if (len >= 4)
			append_byte({2'b10, cp[17:12]});
		if (len >= 3)
			append_byte({2'b10, cp[11:6]});
		if (len >= 2)
			append_byte({2'b10, cp[5:0]});
	endfunction

	function automatic logic [7:0] make_lead(input int len);
		logic [7:0] r;
		r = 8'($urandom_range(255));
		case (len)
			1: return {3'b110, r[4:0]};
			2: return {4'b1110, r[3:0]};
			default: return {5'b11110, r[2:0]};
		endcase
	endfunction

	// Codepoint in or just outside one of the script ranges.
	function automatic logic [20:0] pick_script_cp(input int first, input int last);
		int          k;
		logic [20:0] lo;
		logic [20:0] hi;
		k  = $urandom_range(last, first);
		lo = {5'd0, utf8sd_pkg::SCRIPT_RANGES[k].lo};
		hi = {5'd0, utf8sd_pkg::SCRIPT_RANGES[k].hi};
		case ($urandom_range(7))
			0: return lo;
			1: return hi;
			2: return lo - 21'd1;
			3: return hi + 21'd1;
			default: return 21'($urandom_range(hi, lo));
		endcase
	endfunction

	// Build one random text: mostly well-formed codepoints with random
	// content, mixed with stray bytes and cut-off sequences.
	task make_random_text();
		int          units;
		int          len;
		int          sel;
		logic [20:0] cp;
		units = ($urandom_range(3) == 0) ? 1 : $urandom_range(7, 2);
		repeat (units) begin
			sel = $urandom_range(99);
			if (sel < 35) begin
				cp  = pick_script_cp(0, 9);
				len = min_len(cp) + (($urandom_range(9) == 0) ? 1 : 0);
				push_cp(cp, (len > 4) ? 4 : len);
			end else if (sel < 55) begin
				append_byte(8'($urandom_range(127)));
			end else if (sel < 70) begin
				cp  = 21'($urandom_range(21'h1FFFFF));
				len = min_len(cp) + $urandom_range(1);
				push_cp(cp, (len > 4) ? 4 : len);
			end else if (sel < 80) begin
				append_byte($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
					: 8'($urandom_range(8'hFF, 8'hF8)));
			end else if (sel < 92) begin
				append_byte(8'($urandom_range(255)));
			end else begin
				len = $urandom_range(3, 1);
				append_byte(make_lead(len));
				repeat ($urandom_range(len - 1))
					append_byte(8'($urandom_range(255)));
			end
		end
		// Some texts end inside an open sequence so the held bytes get
		// decoded again on their own.
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(3))
				0: append_byte(make_lead($urandom_range(3, 1)));
				1: begin
					append_byte(make_lead(3));
					push_cp($urandom_range(1) ? pick_script_cp(0, 1)
						: 21'($urandom_range(21'h7FF)), 2);
				end
				2: begin
					len = $urandom_range(3, 2);
					append_byte(make_lead(len));
					repeat ($urandom_range(len - 1, 1))
						append_byte(8'($urandom_range(255)));
				end
				default: begin
					append_byte(make_lead(3));
					append_byte(8'($urandom_range(127)));
					append_byte(8'($urandom_range(255)));
				end
			endcase
		end
	endtask

	initial begin
		int scripts_seen;
		sb = new();
		sb.clear_decoder();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed texts: ASCII extremes, stray bytes, a latched first match,
		// three- and four-byte forms, a lead as the last byte and a rescan of
		// held bytes at the end of a text.
		text_q = {8'h00, 8'h7F};
		send_text();
		text_q = {8'hFF};
		send_text();
		text_q = {8'h80, 8'hBF, 8'hF8};
		send_text();
		text_q = {8'hD8, 8'h80, 8'hD7, 8'h90};
		send_text();
		text_q = {8'hD6, 8'h90};
		send_text();
		text_q = {8'hE4, 8'hB8, 8'h80};
		send_text();
		text_q = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41};
		send_text();
		text_q = {8'h41, 8'hE3};
		send_text();
		text_q = {8'hF0, 8'hD7, 8'hBF};
		send_text();

		// Random texts under three idle mixes.
		while (random_bytes < RANDOM_BYTES) begin
			if (random_bytes >= 2 * RANDOM_BYTES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (random_bytes >= RANDOM_BYTES / 3) begin
				send_idle_pct = 87;
				recv_idle_pct = 13;
			end
			make_random_text();
			random_bytes += text_q.size();
			send_text();
		end
		in_valid <= 1'b0;

		// Drain the remaining results, then let the block settle.
		while (sb.verdict_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.verdict_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.verdict_q.size()));

		scripts_seen = 0;
		foreach (sb.script_hits[k])
			if (sb.script_hits[k] != 0)
				scripts_seen++;
		$display("Sent %0d bytes in %0d texts; checked %0d results, %0d mismatches.",
			bytes_sent, sb.texts_done, sb.results_seen, sb.mismatches);
		$display("Reported %0d of 11 script codes; %0d texts ended in an open sequence.",
			scripts_seen, sb.open_at_end);
		if (sb.mismatches == 0)
			$display("PASS utf8_script_detector");
		else
			$display("FAIL utf8_script_detector");
		$finish;
	end

endmodule
